// ===== rtl/core/sab_pkg.sv =====
// shared types, constants and helper functions for the sample average led bar
`default_nettype none

package sab_pkg;

    localparam int WINDOW_DEF   = 10;
    localparam int RAW_W        = 10;
    localparam int SCALED_W     = 5;
    localparam int LED_W        = 4;
    localparam int LIMIT_W      = 5;
    localparam int TOGGLE_W     = 6;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_INDEX_W  = 2;
    localparam int ACTION_W     = 2;
    localparam int PRODUCT_W    = 15;

    localparam int FULL_SCALE       = 1023;
    localparam int FULL_SCALE_SHIFT = 10;
    localparam int SCALE_TENTHS     = 30;

    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUTTON = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_ONE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_TWO   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_THREE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK       = 2'd3;

    localparam logic [LIMIT_W-1:0]  LEVEL_ONE_RST   = 5'd10;
    localparam logic [LIMIT_W-1:0]  LEVEL_TWO_RST   = 5'd20;
    localparam logic [LIMIT_W-1:0]  LEVEL_THREE_RST = 5'd30;
    localparam logic [TOGGLE_W-1:0] BLINK_RST       = 6'd50;

    localparam logic [LED_W-1:0] LEDS_FOUR  = 4'hF;
    localparam logic [LED_W-1:0] LEDS_THREE = 4'h7;
    localparam logic [LED_W-1:0] LEDS_TWO   = 4'h3;
    localparam logic [LED_W-1:0] LEDS_ONE   = 4'h1;
    localparam logic [LED_W-1:0] LEDS_OFF   = 4'h0;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [RAW_W-1:0]    raw_sample;
        logic                read_failed;
    } sab_in_t;

    typedef struct packed {
        logic [LED_W-1:0]    led_pattern;
        logic [SCALED_W-1:0] window_average;
        logic                blinking;
    } sab_out_t;

    typedef struct packed {
        logic                full;
        logic                full_new;
        logic [SCALED_W-1:0] avg_cur;
        logic [SCALED_W-1:0] avg_new;
    } sab_win_t;

    function automatic logic [SCALED_W-1:0] scale_sample(
        input logic [RAW_W-1:0] raw,
        input logic             failed
    );
        logic [PRODUCT_W-1:0] product;
        logic [PRODUCT_W-1:0] quotient;
        begin
            product  = PRODUCT_W'(SCALE_TENTHS) * PRODUCT_W'(raw);
            // divide by one below a power of two: fold the upper bits back in
            quotient = (product + (product >> FULL_SCALE_SHIFT) + PRODUCT_W'(1))
                       >> FULL_SCALE_SHIFT;
            scale_sample = failed ? '0 : quotient[SCALED_W-1:0];
        end
    endfunction

    function automatic logic [LED_W-1:0] bar_pattern(
        input logic [SCALED_W-1:0] avg,
        input logic [LIMIT_W-1:0]  lim_one,
        input logic [LIMIT_W-1:0]  lim_two,
        input logic [LIMIT_W-1:0]  lim_three
    );
        begin
            if (avg < lim_one) begin
                bar_pattern = LEDS_FOUR;
            end else if (avg < lim_two) begin
                bar_pattern = LEDS_THREE;
            end else if (avg < lim_three) begin
                bar_pattern = LEDS_TWO;
            end else begin
                bar_pattern = LEDS_ONE;
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sample_average_led_bar_unit.sv =====
// top level of the sample average led bar indicator
// usage:
//   in channel carries one word per event: a sample (10-bit reading plus a
//   failed flag), a button press or a blink tick, with valid/ready handshake
//   out channel returns led pattern, window average and blink flag; a word
//   is produced for every sample outside blinking once the averaging window
//   has filled, for every button press, and for every tick while blinking
//   config port writes the three thresholds and the toggle count at any time
//   the block is idle, effective on the next word
// timing:
//   a result word is registered and appears in the cycle after the input word is accepted
//   one word per cycle is accepted while the result register is empty or
//   being read; the running sum, average and pattern are formed
//   combinationally between the state registers and the result register
// reset clears the window, stops blinking, lights all leds and loads the
//   default thresholds; no clearing pass is needed
// when the receiver stalls the result register holds its word and input is
//   taken only in the cycle the waiting word leaves
`default_nettype none

module sample_average_led_bar_unit #(
    parameter int WINDOW = sab_pkg::WINDOW_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire sab_pkg::sab_in_t                 in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output sab_pkg::sab_out_t                     out_data,
    input  wire logic                             cfg_we,
    input  wire logic [sab_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sab_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sab_pkg::*;

    logic                accept;
    logic                push;
    logic [SCALED_W-1:0] scaled;
    logic                res_valid;
    sab_out_t            res;
    sab_win_t            win;
    logic                out_valid_reg;
    sab_out_t            out_data_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    sab_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .scaled (scaled),
        .win    (win)
    );

    sab_indicator u_indicator (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .word      (in_data),
        .win       (win),
        .push      (push),
        .scaled    (scaled),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sab_window.sv =====
// sample ring with running sum and window average
`default_nettype none

module sab_window #(
    parameter int WINDOW = sab_pkg::WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [sab_pkg::SCALED_W-1:0]  scaled,
    output sab_pkg::sab_win_t                  win
);
    import sab_pkg::*;

    localparam int POS_W = $clog2(WINDOW);
    localparam int SUM_W = $clog2(WINDOW * SCALE_TENTHS + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
    localparam int RECIP_SHIFT = SUM_W + 5;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int DIV_PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT + WINDOW - 1) / WINDOW);

    logic [SCALED_W-1:0] mem [WINDOW];
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                full_reg;
    logic                full_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    sum_after;
    logic [SCALED_W-1:0] oldest_reg;
    logic                last;

    // divide by the window length through a reciprocal multiply
    function automatic logic [SCALED_W-1:0] window_div(input logic [SUM_W-1:0] total);
        logic [DIV_PROD_W-1:0] prod;
        begin
            prod       = DIV_PROD_W'(total) * DIV_PROD_W'(RECIP);
            window_div = SCALED_W'(prod >> RECIP_SHIFT);
        end
    endfunction

    assign last      = (pos_reg == POS_LAST);
    assign sum_after = sum_reg - (full_reg ? SUM_W'(oldest_reg) : '0) + SUM_W'(scaled);

    always_comb
    begin
        pos_next  = pos_reg;
        full_next = full_reg;
        sum_next  = sum_reg;
        if (push)
        begin
            pos_next  = last ? '0 : pos_reg + 1'b1;
            full_next = full_reg | last;
            sum_next  = sum_after;
        end
    end

    always_comb
    begin
        win.full     = full_reg;
        win.full_new = full_reg | last;
        win.avg_cur  = full_reg ? window_div(sum_reg) : '0;
        win.avg_new  = window_div(sum_after);
    end

    // entry to be replaced next is read ahead of its push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[pos_reg] <= scaled;
        end
        oldest_reg <= mem[pos_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            full_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            full_reg <= full_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sab_indicator.sv =====
// threshold registers, led state and blink sequencing
`default_nettype none

module sab_indicator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [sab_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sab_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             accept,
    input  wire sab_pkg::sab_in_t                 word,
    input  wire sab_pkg::sab_win_t                win,
    output logic                                  push,
    output logic [sab_pkg::SCALED_W-1:0]          scaled,
    output logic                                  res_valid,
    output sab_pkg::sab_out_t                     res
);
    import sab_pkg::*;

    logic [LIMIT_W-1:0]  lim_one_reg;
    logic [LIMIT_W-1:0]  lim_two_reg;
    logic [LIMIT_W-1:0]  lim_three_reg;
    logic [TOGGLE_W-1:0] blink_limit_reg;
    logic [LED_W-1:0]    led_reg;
    logic [LED_W-1:0]    led_next;
    logic                blink_reg;
    logic                blink_next;
    logic [TOGGLE_W-1:0] count_reg;
    logic [TOGGLE_W-1:0] count_next;
    logic [TOGGLE_W-1:0] count_inc;
    logic [SCALED_W-1:0] avg_out;

    assign scaled    = scale_sample(word.raw_sample, word.read_failed);
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        led_next   = led_reg;
        blink_next = blink_reg;
        count_next = count_reg;
        push       = 1'b0;
        res_valid  = 1'b0;
        avg_out    = win.avg_cur;
        if (accept)
        begin
            case (word.action)
                ACT_SAMPLE:
                begin
                    if (!blink_reg)
                    begin
                        push = 1'b1;
                        if (win.full_new)
                        begin
                            avg_out   = win.avg_new;
                            led_next  = bar_pattern(win.avg_new, lim_one_reg,
                                                    lim_two_reg, lim_three_reg);
                            res_valid = 1'b1;
                        end
                    end
                end
                ACT_BUTTON:
                begin
                    if (!blink_reg)
                    begin
                        led_next   = LEDS_OFF;
                        blink_next = 1'b1;
                        count_next = '0;
                    end
                    res_valid = 1'b1;
                end
                ACT_TICK:
                begin
                    if (blink_reg)
                    begin
                        led_next   = ~led_reg;
                        count_next = count_inc;
                        if (count_inc >= blink_limit_reg)
                        begin
                            blink_next = 1'b0;
                            count_next = '0;
                        end
                        res_valid = 1'b1;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        res.led_pattern    = led_next;
        res.window_average = avg_out;
        res.blinking       = blink_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_one_reg     <= LEVEL_ONE_RST;
            lim_two_reg     <= LEVEL_TWO_RST;
            lim_three_reg   <= LEVEL_THREE_RST;
            blink_limit_reg <= BLINK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEVEL_ONE:   lim_one_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_LEVEL_TWO:   lim_two_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_LEVEL_THREE: lim_three_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_BLINK:       blink_limit_reg <= cfg_data[TOGGLE_W-1:0];
                default:         lim_one_reg     <= lim_one_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg   <= LEDS_FOUR;
            blink_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            led_reg   <= led_next;
            blink_reg <= blink_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for the sample average led bar unit
`timescale 1ns / 100ps

module tb;

    import sab_pkg::*;

    localparam int IDLE_PCT      = 38;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        bit                     is_reg;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        sab_in_t                word;
        logic [7:0]             reps;
        bit                     pinned;
        sab_out_t               want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    sab_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    sab_out_t               out_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // fixed expectation travelling with the word on the bus
    bit        word_pinned = 1'b0;
    sab_out_t  pinned_word = '0;

    bit        steady = 1'b0;
    bit        hold_off_req = 1'b0;
    int        errors = 0;
    int        words_answered = 0;
    int        quiet_cycles = 0;
    int        reading_level = 512;
    sab_out_t  indicator_due[$];
    plan_row_t plan[$];

    // predictor state
    logic [SCALED_W-1:0] win_vals[WINDOW_DEF] = '{default: '0};
    int                  win_pos = 0;
    bit                  win_full = 1'b0;
    bit                  blink_on = 1'b0;
    int                  toggles_done = 0;
    logic [LED_W-1:0]    leds = LEDS_FOUR;
    logic [LIMIT_W-1:0]  lim_one = LEVEL_ONE_RST;
    logic [LIMIT_W-1:0]  lim_two = LEVEL_TWO_RST;
    logic [LIMIT_W-1:0]  lim_three = LEVEL_THREE_RST;
    logic [TOGGLE_W-1:0] blink_len = BLINK_RST;

    sample_average_led_bar_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [SCALED_W-1:0] window_avg();
        int sum;
        int k;
        sum = 0;
        if (!win_full)
        begin
            return '0;
        end
        for (k = 0; k < WINDOW_DEF; k++)
        begin
            sum += win_vals[k];
        end
        return SCALED_W'(sum / WINDOW_DEF);
    endfunction

    function automatic logic [LED_W-1:0] leds_for(input logic [SCALED_W-1:0] avg);
        if (avg < lim_one)
        begin
            return LEDS_FOUR;
        end
        if (avg < lim_two)
        begin
            return LEDS_THREE;
        end
        if (avg < lim_three)
        begin
            return LEDS_TWO;
        end
        return LEDS_ONE;
    endfunction

    function automatic bit advance_indicator(input sab_in_t w, output sab_out_t r);
        bit answers;
        int prod;
        answers = 1'b0;
        case (w.action)
            ACT_SAMPLE:
            begin
                if (!blink_on)
                begin
                    prod = SCALE_TENTHS * int'(w.raw_sample);
                    win_vals[win_pos] = w.read_failed ? '0 : SCALED_W'(prod / FULL_SCALE);
                    win_pos++;
                    if (win_pos == WINDOW_DEF)
                    begin
                        win_pos = 0;
                        win_full = 1'b1;
                    end
                    if (win_full)
                    begin
                        leds = leds_for(window_avg());
                        answers = 1'b1;
                    end
                end
            end
            ACT_BUTTON:
            begin
                if (!blink_on)
                begin
                    leds = LEDS_OFF;
                    blink_on = 1'b1;
                    toggles_done = 0;
                end
                answers = 1'b1;
            end
            ACT_TICK:
            begin
                if (blink_on)
                begin
                    leds = ~leds;
                    toggles_done = (toggles_done + 1) % 64;
                    if (toggles_done >= int'(blink_len))
                    begin
                        blink_on = 1'b0;
                        toggles_done = 0;
                    end
                    answers = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.led_pattern    = leds;
        r.window_average = window_avg();
        r.blinking       = blink_on;
        return answers;
    endfunction

    task automatic check_indicator(input sab_out_t want, input sab_out_t got);
        if (got.led_pattern !== want.led_pattern)
        begin
            errors++;
            $error("led_pattern: expected %h, got %h", want.led_pattern, got.led_pattern);
        end
        if (got.window_average !== want.window_average)
        begin
            errors++;
            $error("window_average: expected %0d, got %0d",
                   want.window_average, got.window_average);
        end
        if (got.blinking !== want.blinking)
        begin
            errors++;
            $error("blinking: expected %b, got %b", want.blinking, got.blinking);
        end
    endtask

    always @(posedge clk)
    begin
        sab_out_t want;
        if (out_valid && out_ready)
        begin
            if (indicator_due.size() == 0)
            begin
                errors++;
                $error("result word with nothing expected");
            end
            else
            begin
                check_indicator(indicator_due.pop_front(), out_data);
            end
        end
        if (in_valid && in_ready)
        begin
            if (advance_indicator(in_data, want))
            begin
                indicator_due.push_back(word_pinned ? pinned_word : want);
                words_answered++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("sample_average_led_bar_unit: mismatch");
                $finish;
            end
        end
    end

    // receiver: random stalls, optional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [RAW_W-1:0] pick_reading();
        int v;
        if ($urandom_range(19) == 0)
        begin
            reading_level = $urandom_range(FULL_SCALE);
        end
        case ($urandom_range(9))
            0: v = 0;
            1: v = FULL_SCALE;
            2, 3, 4, 5: v = reading_level + int'($urandom_range(80)) - 40;
            default: v = $urandom_range(FULL_SCALE);
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > FULL_SCALE)
        begin
            v = FULL_SCALE;
        end
        return v[RAW_W-1:0];
    endfunction

    function automatic sab_in_t rand_word(input logic [ACTION_W-1:0] act);
        sab_in_t w;
        w.action      = act;
        w.raw_sample  = pick_reading();
        w.read_failed = ($urandom_range(11) == 0);
        return w;
    endfunction

    function automatic plan_row_t word_row(input logic [ACTION_W-1:0] act, input int raw,
                                           input bit failed, input int reps);
        plan_row_t r;
        r = '0;
        r.word.action      = act;
        r.word.raw_sample  = RAW_W'(raw);
        r.word.read_failed = failed;
        r.reps             = 8'(reps);
        return r;
    endfunction

    function automatic plan_row_t pinned_row(input logic [ACTION_W-1:0] act, input int raw,
                                             input bit failed, input logic [LED_W-1:0] led,
                                             input int avg, input bit blinking);
        plan_row_t r;
        r = word_row(act, raw, failed, 1);
        r.pinned              = 1'b1;
        r.want.led_pattern    = led;
        r.want.window_average = SCALED_W'(avg);
        r.want.blinking       = blinking;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx, input int value);
        plan_row_t r;
        r = '0;
        r.is_reg    = 1'b1;
        r.reg_index = idx;
        r.reg_value = CFG_DATA_W'(value);
        return r;
    endfunction

    task automatic send_word(input sab_in_t w, input bit pin, input sab_out_t pinned);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_data     <= w;
        word_pinned <= pin;
        pinned_word <= pinned;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        // let the last accepted word reach the predictor queue first
        @(posedge clk);
        while (indicator_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_LEVEL_ONE:   lim_one = value[LIMIT_W-1:0];
            CFG_LEVEL_TWO:   lim_two = value[LIMIT_W-1:0];
            CFG_LEVEL_THREE: lim_three = value[LIMIT_W-1:0];
            CFG_BLINK:       blink_len = value[TOGGLE_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic random_traffic(input int target);
        int goal;
        int ticks;
        int pick;
        goal = words_answered + target;
        while (words_answered < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                // button, then enough ticks to finish the blink sequence
                send_word(rand_word(ACT_BUTTON), 1'b0, '0);
                ticks = (blink_len == 0) ? 1 : int'(blink_len);
                ticks += ($urandom_range(3) == 0) ? 1 : 0;
                repeat (ticks)
                begin
                    if ($urandom_range(15) == 0)
                    begin
                        send_word(rand_word(($urandom_range(1) == 0) ? ACT_SAMPLE : ACT_BUTTON),
                                  1'b0, '0);
                    end
                    send_word(rand_word(ACT_TICK), 1'b0, '0);
                end
            end
            else if (pick < 12)
            begin
                send_word(rand_word(($urandom_range(1) == 0) ? ACT_TICK : ACT_UNUSED), 1'b0, '0);
            end
            else
            begin
                send_word(rand_word(ACT_SAMPLE), 1'b0, '0);
            end
        end
    endtask

    task automatic run_phase(input int l1, input int l2, input int l3, input int blink,
                             input int target, input bit hold);
        settle();
        write_reg(CFG_LEVEL_ONE, CFG_DATA_W'(l1));
        write_reg(CFG_LEVEL_TWO, CFG_DATA_W'(l2));
        write_reg(CFG_LEVEL_THREE, CFG_DATA_W'(l3));
        write_reg(CFG_BLINK, CFG_DATA_W'(blink));
        reading_level = $urandom_range(FULL_SCALE);
        if (hold)
        begin
            hold_off_req = 1'b1;
        end
        random_traffic(target);
    endtask

    initial
    begin
        int l1;
        int l2;

        // tick and unused code in normal mode, blink start and restart attempt
        plan.push_back(word_row(ACT_TICK, 0, 1'b0, 1));
        plan.push_back(word_row(ACT_UNUSED, FULL_SCALE, 1'b1, 1));
        plan.push_back(pinned_row(ACT_BUTTON, 0, 1'b0, LEDS_OFF, 0, 1'b1));
        plan.push_back(word_row(ACT_SAMPLE, FULL_SCALE, 1'b0, 1));
        plan.push_back(pinned_row(ACT_BUTTON, 0, 1'b0, LEDS_OFF, 0, 1'b1));
        plan.push_back(pinned_row(ACT_TICK, 0, 1'b0, LEDS_FOUR, 0, 1'b1));
        plan.push_back(pinned_row(ACT_TICK, 0, 1'b0, LEDS_OFF, 0, 1'b1));
        // toggle count lowered mid-sequence
        plan.push_back(reg_row(CFG_BLINK, 1));
        plan.push_back(pinned_row(ACT_TICK, 0, 1'b0, LEDS_FOUR, 0, 1'b0));
        // window fill, full scale, failed reads, rounding edges
        plan.push_back(word_row(ACT_SAMPLE, FULL_SCALE, 1'b0, 9));
        plan.push_back(pinned_row(ACT_SAMPLE, FULL_SCALE, 1'b0, LEDS_ONE, 30, 1'b0));
        plan.push_back(word_row(ACT_SAMPLE, 0, 1'b0, 1));
        plan.push_back(word_row(ACT_SAMPLE, FULL_SCALE, 1'b1, 9));
        plan.push_back(pinned_row(ACT_SAMPLE, 0, 1'b0, LEDS_FOUR, 0, 1'b0));
        plan.push_back(word_row(ACT_SAMPLE, FULL_SCALE - 1, 1'b0, 1));
        plan.push_back(word_row(ACT_SAMPLE, 35, 1'b0, 1));
        plan.push_back(word_row(ACT_SAMPLE, 34, 1'b0, 1));
        // threshold extremes and a zero toggle count
        plan.push_back(reg_row(CFG_LEVEL_ONE, 0));
        plan.push_back(reg_row(CFG_LEVEL_TWO, 31));
        plan.push_back(reg_row(CFG_LEVEL_THREE, 31));
        plan.push_back(word_row(ACT_SAMPLE, FULL_SCALE, 1'b0, 2));
        plan.push_back(reg_row(CFG_BLINK, 0));
        plan.push_back(word_row(ACT_BUTTON, 0, 1'b0, 1));
        plan.push_back(word_row(ACT_TICK, 0, 1'b0, 1));
        plan.push_back(word_row(ACT_TICK, 0, 1'b0, 1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                settle();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else
            begin
                repeat (plan[i].reps) send_word(plan[i].word, plan[i].pinned, plan[i].want);
            end
        end

        run_phase(int'(LEVEL_ONE_RST), int'(LEVEL_TWO_RST), int'(LEVEL_THREE_RST),
                  int'(BLINK_RST), 60, 1'b0);
        run_phase(0, 0, 0, 1, 55, 1'b0);
        run_phase(31, 31, 31, 63, 55, 1'b0);
        run_phase(5, 12, 25, 3, 55, 1'b1);
        steady = 1'b1;
        run_phase(8, 16, 24, 2, 55, 1'b0);
        steady = 1'b0;
        l1 = $urandom_range(15);
        l2 = l1 + $urandom_range(8);
        run_phase(l1, l2, l2 + $urandom_range(31 - l2), $urandom_range(1, 8), 55, 1'b1);
        run_phase($urandom_range(31), $urandom_range(31), $urandom_range(31),
                  $urandom_range(63), 55, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("sample_average_led_bar_unit: match");
        end
        else
        begin
            $display("sample_average_led_bar_unit: mismatch");
        end
        $finish;
    end

endmodule
